// ===== hdl/hll_pkg.sv =====
// Package for the cardinality sketch: types, constants and helper functions.
package hll_pkg;

  localparam int MaxPrecision = 16;
  localparam int RegCount     = 1 << MaxPrecision;
  localparam int IdxW         = MaxPrecision;
  localparam int CntW         = MaxPrecision + 1;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_ESTIMATE = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  localparam logic [63:0] Alpha16  = 64'd2890512990;
  localparam logic [63:0] Alpha32  = 64'd2993592205;
  localparam logic [63:0] Alpha64  = 64'd3045131812;
  localparam logic [63:0] AlphaInf = 64'd3097959910;
  localparam logic [31:0] Ln2Q32   = 32'hB17217F7;

  // Bias correction for 128 registers and up, in Q32.
  localparam logic [63:0] AlphaP7  = (AlphaInf * 64'd1000 * 64'd128) /
                                     (64'd1000 * 64'd128 + 64'd1079);
  localparam logic [63:0] AlphaP8  = (AlphaInf * 64'd1000 * 64'd256) /
                                     (64'd1000 * 64'd256 + 64'd1079);
  localparam logic [63:0] AlphaP9  = (AlphaInf * 64'd1000 * 64'd512) /
                                     (64'd1000 * 64'd512 + 64'd1079);
  localparam logic [63:0] AlphaP10 = (AlphaInf * 64'd1000 * 64'd1024) /
                                     (64'd1000 * 64'd1024 + 64'd1079);
  localparam logic [63:0] AlphaP11 = (AlphaInf * 64'd1000 * 64'd2048) /
                                     (64'd1000 * 64'd2048 + 64'd1079);
  localparam logic [63:0] AlphaP12 = (AlphaInf * 64'd1000 * 64'd4096) /
                                     (64'd1000 * 64'd4096 + 64'd1079);
  localparam logic [63:0] AlphaP13 = (AlphaInf * 64'd1000 * 64'd8192) /
                                     (64'd1000 * 64'd8192 + 64'd1079);
  localparam logic [63:0] AlphaP14 = (AlphaInf * 64'd1000 * 64'd16384) /
                                     (64'd1000 * 64'd16384 + 64'd1079);
  localparam logic [63:0] AlphaP15 = (AlphaInf * 64'd1000 * 64'd32768) /
                                     (64'd1000 * 64'd32768 + 64'd1079);
  localparam logic [63:0] AlphaP16 = (AlphaInf * 64'd1000 * 64'd65536) /
                                     (64'd1000 * 64'd65536 + 64'd1079);

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] hash_value;
  } hll_in_t;

  typedef struct packed {
    logic [60:0] estimate_q16;
    logic [16:0] empty_registers;
    logic        linear_counting;
  } hll_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SCAN, ST_ALPHA, ST_DIV, ST_LOGN, ST_LOGF, ST_LN1, ST_LN2, ST_DONE
  } hll_state_t;

  // Clamp the stored precision into the supported range.
  function automatic logic [4:0] eff_bits(input logic [4:0] p);
    logic [4:0] b;
    b = p;
    if (b < 5'd4) b = 5'd4;
    if (b > 5'(MaxPrecision)) b = 5'(MaxPrecision);
    return b;
  endfunction

endpackage

// ===== hdl/hyperloglog_cardinality_sketch.sv =====
// Cardinality sketch top level: request handling, register scan and estimate sequencer.
// Add requests use a read-modify-write on a 65536-entry rank memory: the read is issued when
// the request is taken, then the compare and write back follow. A clear request, and a clearing
// pass after reset, sweep the memory one entry a cycle. An estimate reads the 2^B registers
// in use one a cycle, then runs the divider, a 32-step logarithm squaring loop and the final
// logarithm steps; the squaring loop and final steps are skipped when the raw formula
// applies.
module hyperloglog_cardinality_sketch (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  hll_pkg::hll_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hll_pkg::hll_out_t out_data
);
  import hll_pkg::*;

  hll_state_t state, state_next;
  logic [4:0] precision;
  logic [4:0] b;
  logic [CntW-1:0] cnt;
  logic        add_pend;
  logic [IdxW-1:0] add_idx;
  logic [4:0]  add_rho;
  logic        scan_pend;
  logic [63:0] z;
  logic [CntW-1:0] v;
  logic [63:0] alpha;
  logic [63:0] tmp;
  logic [63:0] est;
  logic [63:0] lx;
  logic [31:0] frac;
  logic [4:0]  vtop;
  logic [5:0]  step;
  logic        sq_phase;
  logic        sq_flag;

  logic        mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [4:0]  mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  logic [4:0]  mem_rdata;

  logic        div_start, div_busy;
  logic [63:0] div_quot;
  logic [CntW-1:0] mreg;

  logic [31:0] w;
  logic [5:0]  lz;
  logic [4:0]  rho;
  logic        accept;

  assign b    = eff_bits(precision);
  assign mreg = CntW'(1) << b;
  assign accept = in_valid && in_ready;

  hll_rank_mem u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  hll_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(tmp), .den(z),
    .busy(div_busy), .quot(div_quot)
  );

  // Leading-zero count of the bits below the index.
  always_comb begin
    w  = in_data.hash_value << b;
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (w[i]) lz = 6'(31 - i);
    end
    rho = (w == 32'd0) ? 5'(6'd33 - {1'b0, b}) : 5'(lz + 6'd1);
  end

  // Position of the top set bit of the empty register count.
  always_comb begin
    vtop = '0;
    for (int i = 0; i < CntW; i++) begin
      if (v[i]) vtop = 5'(i);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_data.command == CMD_ESTIMATE) state_next = ST_SCAN;
        else if (accept && in_data.command == CMD_CLEAR) state_next = ST_CLEAR;
      end
      ST_CLEAR: if (cnt == CntW'(RegCount - 1)) state_next = ST_IDLE;
      ST_SCAN:  if (!scan_pend && cnt == mreg) state_next = ST_ALPHA;
      ST_ALPHA: state_next = ST_DIV;
      ST_DIV:   if (!div_start && !div_busy) state_next = ST_LOGN;
      ST_LOGN:  begin
        if (est <= ((64'(mreg) * 64'd5) << 15) && v != '0) state_next = ST_LOGF;
        else state_next = ST_DONE;
      end
      ST_LOGF:  if (step == 6'd32) state_next = ST_LN1;
      ST_LN1:   state_next = ST_LN2;
      ST_LN2:   state_next = ST_DONE;
      ST_DONE:  if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = (state == ST_IDLE) && !add_pend;
    out_valid = (state == ST_DONE);
    mem_we    = add_pend || state == ST_CLEAR;
    mem_waddr = (state == ST_CLEAR) ? cnt[IdxW-1:0] : add_idx;
    mem_wdata = (state == ST_CLEAR) ? 5'd0
              : ((add_rho > mem_rdata) ? add_rho : mem_rdata);
    mem_raddr = (state == ST_SCAN) ? cnt[IdxW-1:0]
                                   : IdxW'(in_data.hash_value >> (6'd32 - {1'b0, b}));
    div_start = (state == ST_ALPHA);
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      precision <= 5'd12;
      cnt       <= '0;
      add_pend  <= 1'b0;
      scan_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) precision <= cfg_wdata;
      add_pend <= 1'b0;
      // Add: the read is issued this cycle, compare and write back next cycle.
      if (accept && in_data.command == CMD_ADD) begin
        add_pend <= 1'b1;
        add_idx  <= mem_raddr;
        add_rho  <= rho;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          z   <= '0;
          v   <= '0;
          scan_pend <= 1'b0;
        end
        ST_CLEAR: cnt <= cnt + 1'b1;
        ST_SCAN: begin
          if (cnt != mreg) cnt <= cnt + 1'b1;
          scan_pend <= (cnt != mreg);
          if (scan_pend) begin
            z <= z + (64'd1 << (6'd32 - {1'b0, mem_rdata}));
            if (mem_rdata == 5'd0) v <= v + 1'b1;
          end
          // Bias correction constant for the register count in use.
          unique case (b)
            5'd4:    alpha <= Alpha16;
            5'd5:    alpha <= Alpha32;
            5'd6:    alpha <= Alpha64;
            5'd7:    alpha <= AlphaP7;
            5'd8:    alpha <= AlphaP8;
            5'd9:    alpha <= AlphaP9;
            5'd10:   alpha <= AlphaP10;
            5'd11:   alpha <= AlphaP11;
            5'd12:   alpha <= AlphaP12;
            5'd13:   alpha <= AlphaP13;
            5'd14:   alpha <= AlphaP14;
            5'd15:   alpha <= AlphaP15;
            default: alpha <= AlphaP16;
          endcase
        end
        ST_ALPHA: ;
        ST_DIV: begin
          est <= div_quot;
          step <= '0;
          frac <= '0;
          sq_phase <= 1'b0;
        end
        ST_LOGN: lx <= 64'(v) << (5'd31 - vtop);
        ST_LOGF: begin
          sq_phase <= ~sq_phase;
          if (!sq_phase) tmp <= (lx[32:0] * lx[32:0]) >> 31;
          else begin
            step <= step + 6'd1;
            if (tmp[32]) begin
              lx <= tmp >> 1; frac <= {frac[30:0], 1'b1};
            end else begin
              lx <= tmp; frac <= {frac[30:0], 1'b0};
            end
          end
        end
        ST_LN1: lx <= ({27'd0, b, 32'd0}) - {27'd0, vtop, frac};
        ST_LN2: est <= ((64'(lx[63:32]) * 64'(Ln2Q32)
                       + ((64'(lx[31:0]) * 64'(Ln2Q32)) >> 32)) << b) >> 16;
        ST_DONE: ;
        default: ;
      endcase
      // Numerator alpha*m*m; m is a power of two, so this is a shift by 2B.
      if (state == ST_SCAN) tmp <= alpha << {b, 1'b0};
    end
  end

  always_comb begin
    out_data.estimate_q16    = est[60:0];
    out_data.empty_registers = v;
    out_data.linear_counting = sq_flag;
  end

  // Remembers whether the linear counting path was taken.
  always_ff @(posedge clk) begin
    if (rst) sq_flag <= 1'b0;
    else if (state == ST_LOGN) sq_flag <= (state_next == ST_LOGF);
  end
endmodule

// ===== hdl/hll_rank_mem.sv =====
// Rank register memory with one write port and one registered read port.
module hll_rank_mem (
  input  logic                  clk,
  input  logic                  we,
  input  logic [hll_pkg::IdxW-1:0] waddr,
  input  logic [4:0]            wdata,
  input  logic [hll_pkg::IdxW-1:0] raddr,
  output logic [4:0]            rdata
);
  import hll_pkg::*;

  logic [4:0] mem [RegCount];

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/hll_divider.sv =====
// Restoring divider giving floor(num * 2^16 / den), one quotient bit per cycle.
module hll_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [63:0] quot
);
  logic [79:0] dvd;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic [64:0] trial;

  assign trial = {rem[63:0], dvd[79]};

  // Shift one dividend bit into the remainder per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      dvd  <= {num, 16'd0};
      rem  <= '0;
      quot <= '0;
      cnt  <= 7'd79;
    end else if (busy) begin
      dvd <= {dvd[78:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem  <= trial - {1'b0, den};
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[62:0], 1'b0};
      end
      if (cnt == 7'd0) busy <= 1'b0;
      else cnt <= cnt - 7'd1;
    end
  end
endmodule
